FILE: rtl/core/dual_fnv1a_name_uuid_top_macros.svh
// Assertion macros for the dual FNV-1a name identifier block.
`ifndef DUAL_FNV1A_NAME_UUID_TOP_MACROS_SVH
`define DUAL_FNV1A_NAME_UUID_TOP_MACROS_SVH

// Checked only while out of reset.
`define DFNV_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every clock edge, reset included.
`define DFNV_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

FILE: rtl/core/dfnv_pkg.sv
// Package with the seeds, prime and identifier formatting for the dual FNV-1a block.
package dfnv_pkg;

  localparam int unsigned HashW = 64;

  typedef logic [HashW-1:0] hash_t;

  localparam hash_t LaneOneSeed = 64'hcbf2_9ce4_8422_2325;
  localparam hash_t LaneTwoSeed = 64'h9e37_79b9_7f4a_7c15;
  // FNV prime is 2^40 + 0x1b3
  localparam int unsigned PrimeShift = 40;
  localparam hash_t PrimeLow = 64'h0000_0000_0000_01b3;

  localparam hash_t VersionKeep = 64'hffff_ffff_ffff_0fff;
  localparam hash_t VersionFive = 64'h0000_0000_0000_5000;
  localparam hash_t VariantKeep = 64'h3fff_ffff_ffff_ffff;
  localparam hash_t VariantRfc  = 64'h8000_0000_0000_0000;

  // One FNV-1a step: xor the byte in, multiply by the prime mod 2^64
  function automatic hash_t fnv_mix(hash_t h, logic [7:0] b);
    hash_t x;
    x = h ^ {{(HashW-8){1'b0}}, b};
    return (x << PrimeShift) + (x * PrimeLow);
  endfunction

  function automatic hash_t fmt_high(hash_t h);
    return (h & VersionKeep) | VersionFive;
  endfunction

  function automatic hash_t fmt_low(hash_t h);
    return (h & VariantKeep) | VariantRfc;
  endfunction

endpackage

FILE: rtl/core/dual_fnv1a_name_uuid_top.sv
// Dual-lane FNV-1a name hasher that emits a 128-bit version 5 style identifier.
// An end item waits in the input register; its identifier then goes to the result register that drives m_axis.
// Throughput: one item per cycle; set by the single mix step on the input register.
// Items without an end mark never stall; an end item waits only for the result register.
// Reset: asynchronous, active low; clears valid flags and loads both lane seeds.
`include "dual_fnv1a_name_uuid_top_macros.svh"

module dual_fnv1a_name_uuid_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  // input stream
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [7:0]   s_axis_tdata_i,   // [7:0] data_byte
  input  logic         s_axis_tuser_i,   // [0] byte_valid
  input  logic         s_axis_tlast_i,   // end_of_name
  // result stream
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [127:0] m_axis_tdata_o    // [63:0] uuid_high, [127:64] uuid_low
);

  // input register
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_bv_q;
  logic       in_last_q;

  // lane state
  dfnv_pkg::hash_t lane1_q, lane1_d;
  dfnv_pkg::hash_t lane2_q, lane2_d;
  dfnv_pkg::hash_t mix1, mix2;

  // result register
  logic            out_valid_q, out_valid_d;
  dfnv_pkg::hash_t out_high_q, out_low_q;

  logic out_free;
  logic fire;

  // the result register can take a new identifier when empty or being drained
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign fire     = in_valid_q && (!in_last_q || out_free);
  assign s_axis_tready_o = !in_valid_q || fire;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i;
      in_bv_q   <= s_axis_tuser_i;
      in_last_q <= s_axis_tlast_i;
    end
  end

  // mix step for both lanes
  always_comb begin
    mix1    = in_bv_q ? dfnv_pkg::fnv_mix(lane1_q, in_byte_q) : lane1_q;
    mix2    = in_bv_q ? dfnv_pkg::fnv_mix(lane2_q, in_byte_q) : lane2_q;
    lane1_d = lane1_q;
    lane2_d = lane2_q;
    if (fire) begin
      lane1_d = in_last_q ? dfnv_pkg::LaneOneSeed : mix1;
      lane2_d = in_last_q ? dfnv_pkg::LaneTwoSeed : mix2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane1_q <= dfnv_pkg::LaneOneSeed;
      lane2_q <= dfnv_pkg::LaneTwoSeed;
    end else begin
      lane1_q <= lane1_d;
      lane2_q <= lane2_d;
    end
  end

  // result register
  always_comb begin
    out_valid_d = out_valid_q && !m_axis_tready_i;
    if (fire && in_last_q) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && in_last_q) begin
      out_high_q <= dfnv_pkg::fmt_high(mix1);
      out_low_q  <= dfnv_pkg::fmt_low(mix2);
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_low_q, out_high_q};

  // checks
  `DFNV_ASSERT(a_fmt_bits, out_valid_q |-> (out_high_q[15:12] == 4'b0101 && out_low_q[63:62] == 2'b10), "identifier format bits wrong")
  `DFNV_ASSERT(a_no_overwrite, (out_valid_q && !m_axis_tready_i) |-> !(fire && in_last_q), "pending identifier overwritten")
  `DFNV_ASSERT(a_reseed, (fire && in_last_q) |=> (lane1_q == dfnv_pkg::LaneOneSeed && lane2_q == dfnv_pkg::LaneTwoSeed), "lanes not reseeded after end item")
  `DFNV_ASSERT_ALWAYS(a_no_stall_mid, (in_valid_q && !in_last_q) |-> fire, "non-end item stalled")

endmodule

FILE: verif/tb_top.sv
// Testbench for the dual-lane FNV-1a name identifier block: directed names plus random names.
`timescale 1ns / 100ps

module tb_top;

  localparam logic [63:0] SeedOne     = 64'hcbf29ce484222325;
  localparam logic [63:0] SeedTwo     = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] FnvPrime    = 64'h00000100000001b3;
  localparam logic [63:0] VerMask     = 64'hffffffffffff0fff;
  localparam logic [63:0] VerFive     = 64'h0000000000005000;
  localparam logic [63:0] VarMask     = 64'h3fffffffffffffff;
  localparam logic [63:0] VarTen      = 64'h8000000000000000;
  localparam int          RandItems   = 1700;
  localparam int          StallLimit  = 3000;
  localparam int          HoldCycles  = 300;
  localparam int          HoldAtItem  = 100;
  localparam int          DrainCycles = 10;

  // one name byte as it travels on the input stream
  typedef struct packed {
    logic [7:0] data;
    logic       byte_ok;
    logic       last;
  } name_item_t;

  typedef struct packed {
    logic [63:0] high;
    logic [63:0] low;
  } uuid_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [7:0]   s_axis_tdata_i = '0;  // [7:0] data_byte
  logic         s_axis_tuser_i = 1'b0; // [0] byte_valid
  logic         s_axis_tlast_i = 1'b0; // end_of_name
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [127:0] m_axis_tdata_o;       // [63:0] uuid_high, [127:64] uuid_low

  name_item_t   byte_q[$];
  uuid_t        uuid_q[$];
  logic [63:0]  lane_a = SeedOne;
  logic [63:0]  lane_b = SeedTwo;
  logic         in_took = 1'b0;
  int           total_items = 0;
  int           taken_cnt = 0;
  int           err_cnt = 0;
  int           idle_cnt = 0;
  int           hold_cnt = 0;
  bit           hold_done = 1'b0;

  dual_fnv1a_name_uuid_top DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // xor the byte in, then multiply by the prime mod 2^64
  function automatic logic [63:0] fnv_round(logic [63:0] h, logic [7:0] b);
    return (h ^ {56'd0, b}) * FnvPrime;
  endfunction

  // idle percentages per phase: sender busy first, then receiver, then no idling
  function automatic int send_idle_pct(int n);
    if (n < total_items / 3) return 26;
    if (n < (2 * total_items) / 3) return 86;
    return 0;
  endfunction

  function automatic int recv_idle_pct(int n);
    if (n < total_items / 3) return 86;
    if (n < (2 * total_items) / 3) return 26;
    return 0;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  // advance both lanes; an end item produces the identifier and reseeds
  task automatic hash_name_item(input name_item_t it);
    uuid_t u;
    if (it.byte_ok) begin
      lane_a = fnv_round(lane_a, it.data);
      lane_b = fnv_round(lane_b, it.data);
    end
    if (it.last) begin
      u.high = (lane_a & VerMask) | VerFive;
      u.low  = (lane_b & VarMask) | VarTen;
      uuid_q = {uuid_q, u};
      lane_a = SeedOne;
      lane_b = SeedTwo;
    end
  endtask

  task automatic add_item(input logic [7:0] d, input logic ok, input logic last);
    name_item_t it;
    it.data    = d;
    it.byte_ok = ok;
    it.last    = last;
    byte_q = {byte_q, it};
  endtask

  // input side: offer the next pending item at the falling edge
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else if (!s_axis_tvalid_i || in_took) begin
      if (byte_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct(taken_cnt)) begin
        name_item_t it;
        it = byte_q.pop_front();
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i  <= it.data;
        s_axis_tuser_i  <= it.byte_ok;
        s_axis_tlast_i  <= it.last;
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // accepted input items go through the predictor
  always @(posedge clk_i) begin
    in_took <= s_axis_tvalid_i && s_axis_tready_o && rst_ni;
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o) begin
      name_item_t it;
      it.data    = s_axis_tdata_i;
      it.byte_ok = s_axis_tuser_i;
      it.last    = s_axis_tlast_i;
      hash_name_item(it);
      taken_cnt++;
    end
  end

  // output side readiness, with one long hold-off to back the block up
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      if (!hold_done && taken_cnt >= HoldAtItem) begin
        hold_done = 1'b1;
        hold_cnt  = HoldCycles;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= ($urandom_range(0, 99) >= recv_idle_pct(taken_cnt));
      end
    end
  end

  // compare each identifier with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (uuid_q.size() == 0) begin
        report_mismatch($sformatf("unexpected identifier %h", m_axis_tdata_o));
      end else begin
        uuid_t u;
        u = uuid_q.pop_front();
        if (m_axis_tdata_o[63:0] !== u.high)
          report_mismatch($sformatf("uuid_high got %h want %h", m_axis_tdata_o[63:0], u.high));
        if (m_axis_tdata_o[127:64] !== u.low)
          report_mismatch($sformatf("uuid_low got %h want %h", m_axis_tdata_o[127:64], u.low));
      end
    end
  end

  // watchdog on cycles where neither side moves an item
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
        idle_cnt <= 0;
      end else if (idle_cnt + 1 >= StallLimit) begin
        $display("Simulation FAILED");
        $finish;
      end else begin
        idle_cnt <= idle_cnt + 1;
      end
    end
  end

  // stimulus and end of run
  initial begin
    int counted;
    int len;
    counted = 0;

    // directed: empty names, single-byte extremes, end with and without a byte
    add_item(8'h00, 1'b0, 1'b1);
    add_item(8'hff, 1'b0, 1'b1);
    add_item(8'h00, 1'b1, 1'b1);
    add_item(8'hff, 1'b1, 1'b1);
    add_item(8'h80, 1'b1, 1'b0);
    add_item(8'h5a, 1'b0, 1'b1);
    // ignored item in the middle of a name
    add_item(8'h61, 1'b1, 1'b0);
    add_item(8'ha5, 1'b0, 1'b0);
    add_item(8'h62, 1'b1, 1'b1);
    add_item(8'h01, 1'b1, 1'b0);
    add_item(8'h7f, 1'b1, 1'b0);
    add_item(8'hfe, 1'b1, 1'b0);
    add_item(8'h00, 1'b0, 1'b1);
    for (int i = 0; i < 8; i++) add_item(8'hff, 1'b1, i == 7);
    add_item(8'h00, 1'b0, 1'b1);

    // random names, mostly short, a few long, with ignored items sprinkled in
    while (counted < RandItems) begin
      len = ($urandom_range(0, 9) == 0) ? int'($urandom_range(13, 48))
                                         : int'($urandom_range(0, 12));
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          add_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        end else begin
          add_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
        end
        counted++;
      end
      add_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
      counted++;
    end
    total_items = byte_q.size();

    repeat (2) @(posedge clk_i);
    #1 rst_ni <= 1'b1;

    while (byte_q.size() != 0 || s_axis_tvalid_i || uuid_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (uuid_q.size() != 0)
      report_mismatch($sformatf("%0d identifiers never arrived", uuid_q.size()));
    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
